[hdl/atb_pkg.sv]
// Shared types and constants for the analog trigger to button block.
package atb_pkg;

  localparam int unsigned DefValueWidth = 16;
  localparam int unsigned CfgAddrWidth  = 5;
  localparam int unsigned CfgDataWidth  = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_FAST_MODE = 3'd0;
  localparam logic [2:0] REG_PRESS_THR = 3'd1;
  localparam logic [2:0] REG_MARGIN    = 3'd2;
  localparam logic [2:0] REG_DEAD_ZONE = 3'd3;
  localparam logic [2:0] REG_LOWER_LIM = 3'd4;
  localparam logic [2:0] REG_UPPER_LIM = 3'd5;

  // Register reset values
  localparam logic               RST_FAST_MODE = 1'b0;
  localparam logic signed [15:0] RST_PRESS_THR = 16'sd16384;
  localparam logic        [14:0] RST_MARGIN    = 15'd3277;
  localparam logic        [14:0] RST_DEAD_ZONE = 15'd0;
  localparam logic signed [15:0] RST_LOWER_LIM = -16'sd32767;
  localparam logic signed [15:0] RST_UPPER_LIM = 16'sd32767;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_ADD = 2'd1,
    OP_NEG = 2'd2,
    OP_CLR = 2'd3
  } op_t;

  typedef struct packed {
    logic        fast_mode;
    logic [15:0] press_thr;
    logic [14:0] margin;
    logic [14:0] dead_zone;
    logic [15:0] lower_lim;
    logic [15:0] upper_lim;
  } cfg_t;

  typedef struct packed {
    logic button_down;
    logic press_edge;
    logic release_edge;
    logic value_changed;
    logic axis_active;
  } res_flags_t;

endpackage

[hdl/atb_step.sv]
// Next-state and result logic for one trigger operation.
module atb_step import atb_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  cfg_t                          cfg,
  input  op_t                           op,
  input  logic signed [15:0]            sample,
  input  logic signed [VALUE_WIDTH-1:0] cur,
  input  logic signed [VALUE_WIDTH-1:0] prev,
  input  logic signed [VALUE_WIDTH-1:0] peak,
  input  logic signed [VALUE_WIDTH-1:0] rel,
  input  logic                          btn,
  output logic signed [VALUE_WIDTH-1:0] cur_nxt,
  output logic signed [VALUE_WIDTH-1:0] prev_nxt,
  output logic signed [VALUE_WIDTH-1:0] peak_nxt,
  output logic signed [VALUE_WIDTH-1:0] rel_nxt,
  output logic                          btn_nxt,
  output res_flags_t                    flags,
  output logic signed [15:0]            axis_value
);

  localparam int unsigned WW = ((VALUE_WIDTH > 16) ? VALUE_WIDTH : 16) + 2;
  localparam logic signed [WW-1:0] VMAX_W = WW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] VMIN_W = -VMAX_W - WW'(1);

  logic signed [WW-1:0] cur_w, prev_w, peak_w, rel_w, smp_w;
  logic signed [WW-1:0] thr_w, lo_w, hi_w, mrg_w, dead_w;
  logic signed [WW-1:0] raw_v, lo_v, hi_v, clamp_v, neg_v, neg_sat;
  logic signed [WW-1:0] pk_up, mag;
  logic signed [WW-1:0] cur_n, prev_n, peak_n, rel_n;
  logic                 btn_n, store;

  assign cur_w  = WW'(cur);
  assign prev_w = WW'(prev);
  assign peak_w = WW'(peak);
  assign rel_w  = WW'(rel);
  assign smp_w  = WW'(sample);
  assign thr_w  = WW'($signed(cfg.press_thr));
  assign lo_w   = WW'($signed(cfg.lower_lim));
  assign hi_w   = WW'($signed(cfg.upper_lim));
  assign mrg_w  = WW'($signed({1'b0, cfg.margin}));
  assign dead_w = WW'($signed({1'b0, cfg.dead_zone}));

  // Lower limit first, then upper, then the storage range
  assign raw_v   = (op == OP_SET) ? smp_w : (cur_w + smp_w);
  assign lo_v    = (raw_v < lo_w) ? lo_w : raw_v;
  assign hi_v    = (lo_v > hi_w) ? hi_w : lo_v;
  assign clamp_v = (hi_v > VMAX_W) ? VMAX_W : ((hi_v < VMIN_W) ? VMIN_W : hi_v);

  assign neg_v   = -cur_w;
  assign neg_sat = (neg_v > VMAX_W) ? VMAX_W : neg_v;

  assign pk_up = (clamp_v > peak_w) ? clamp_v : peak_w;
  assign store = (op == OP_SET) || ((op == OP_ADD) && (sample != 16'sd0));

  always_comb begin
    cur_n  = cur_w;
    prev_n = prev_w;
    peak_n = peak_w;
    rel_n  = rel_w;
    btn_n  = btn;
    case (op)
      OP_SET, OP_ADD: begin
        if (store) begin
          prev_n = cur_w;
          cur_n  = clamp_v;
          if (!cfg.fast_mode) begin
            btn_n = (clamp_v >= thr_w);
          end else if (clamp_v >= thr_w) begin
            peak_n = pk_up;
            if (!btn) begin
              if (clamp_v > rel_w + mrg_w) begin
                btn_n = 1'b1;
                rel_n = clamp_v;
              end
            end else if (clamp_v < pk_up - mrg_w) begin
              btn_n  = 1'b0;
              rel_n  = clamp_v;
              peak_n = clamp_v;
            end
          end else if (btn) begin
            // forced up below threshold
            if (clamp_v < peak_w - mrg_w) begin
              rel_n  = clamp_v;
              peak_n = clamp_v;
            end
            btn_n = 1'b0;
          end else begin
            peak_n = '0;
            rel_n  = '0;
          end
        end
      end
      OP_NEG: begin
        cur_n = neg_sat;
      end
      OP_CLR: begin
        cur_n  = '0;
        prev_n = '0;
        peak_n = '0;
        rel_n  = '0;
        btn_n  = 1'b0;
      end
      default: ;
    endcase
  end

  assign mag = (cur_n < 0) ? -cur_n : cur_n;

  assign cur_nxt  = cur_n[VALUE_WIDTH-1:0];
  assign prev_nxt = prev_n[VALUE_WIDTH-1:0];
  assign peak_nxt = peak_n[VALUE_WIDTH-1:0];
  assign rel_nxt  = rel_n[VALUE_WIDTH-1:0];
  assign btn_nxt  = btn_n;

  assign flags.button_down   = btn_n;
  assign flags.press_edge    = store && !btn && btn_n;
  assign flags.release_edge  = store && btn && !btn_n;
  assign flags.value_changed = (cur_n != prev_n);
  assign flags.axis_active   = (mag > dead_w);
  assign axis_value          = cur_n[15:0];

endmodule

[hdl/analog_trigger_to_button.sv]
// Top level: analog trigger value to digital button with rapid-trigger hysteresis.
//
// Input channel (in_valid / in_stall) carries one operation per beat: set, add,
// negate or clear, with a signed Q1.15 sample. Result channel (out_valid /
// out_stall) returns exactly one beat per input beat: button level, press and
// release edges, value-changed and axis-active flags, and the current value.
// Configuration registers sit on an APB-style port at byte address 4 * index;
// write them only while no beat is in flight.
// An accepted beat waits in the input register; the state update and the result
// register load then take place together.
// Throughput is one beat per cycle while the receiver does not stall; the stored
// levels feed back through a single clamp, compare and select path, which sets that figure.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; in_stall rises only once both are full.
// Synchronous active-low reset empties both registers, zeroes all levels,
// puts the button up and loads the register defaults.
module analog_trigger_to_button import atb_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_operation,
  input  logic signed [15:0]      in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_button_down,
  output logic                    out_press_edge,
  output logic                    out_release_edge,
  output logic                    out_value_changed,
  output logic                    out_axis_active,
  output logic signed [15:0]      out_axis_value,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready
);

  cfg_t                          cfg_r;
  logic                          in_v_r;
  op_t                           op_r;
  logic signed [15:0]            sample_r;
  logic                          out_v_r;
  res_flags_t                    flags_r;
  logic signed [15:0]            axis_r;
  logic signed [VALUE_WIDTH-1:0] cur_r, prev_r, peak_r, rel_r;
  logic                          btn_r;

  logic signed [VALUE_WIDTH-1:0] cur_nxt, prev_nxt, peak_nxt, rel_nxt;
  logic                          btn_nxt;
  res_flags_t                    flags_nxt;
  logic signed [15:0]            axis_nxt;
  logic                          advance, in_take, cfg_wr;
  logic [2:0]                    reg_idx;

  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Result slot is free when empty or being drained this cycle
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_mode <= RST_FAST_MODE;
      cfg_r.press_thr <= RST_PRESS_THR;
      cfg_r.margin    <= RST_MARGIN;
      cfg_r.dead_zone <= RST_DEAD_ZONE;
      cfg_r.lower_lim <= RST_LOWER_LIM;
      cfg_r.upper_lim <= RST_UPPER_LIM;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FAST_MODE: cfg_r.fast_mode <= pwdata[0];
        REG_PRESS_THR: cfg_r.press_thr <= pwdata[15:0];
        REG_MARGIN:    cfg_r.margin    <= pwdata[14:0];
        REG_DEAD_ZONE: cfg_r.dead_zone <= pwdata[14:0];
        REG_LOWER_LIM: cfg_r.lower_lim <= pwdata[15:0];
        REG_UPPER_LIM: cfg_r.upper_lim <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FAST_MODE: prdata = CfgDataWidth'(cfg_r.fast_mode);
      REG_PRESS_THR: prdata = CfgDataWidth'(cfg_r.press_thr);
      REG_MARGIN:    prdata = CfgDataWidth'(cfg_r.margin);
      REG_DEAD_ZONE: prdata = CfgDataWidth'(cfg_r.dead_zone);
      REG_LOWER_LIM: prdata = CfgDataWidth'(cfg_r.lower_lim);
      REG_UPPER_LIM: prdata = CfgDataWidth'(cfg_r.upper_lim);
      default:       prdata = '0;
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r     <= op_t'(in_operation);
      sample_r <= in_sample;
    end
  end

  atb_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .cfg       (cfg_r),
    .op        (op_r),
    .sample    (sample_r),
    .cur       (cur_r),
    .prev      (prev_r),
    .peak      (peak_r),
    .rel       (rel_r),
    .btn       (btn_r),
    .cur_nxt   (cur_nxt),
    .prev_nxt  (prev_nxt),
    .peak_nxt  (peak_nxt),
    .rel_nxt   (rel_nxt),
    .btn_nxt   (btn_nxt),
    .flags     (flags_nxt),
    .axis_value(axis_nxt)
  );

  // Commit state and load the result register together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      prev_r  <= '0;
      peak_r  <= '0;
      rel_r   <= '0;
      btn_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (advance) begin
        cur_r   <= cur_nxt;
        prev_r  <= prev_nxt;
        peak_r  <= peak_nxt;
        rel_r   <= rel_nxt;
        btn_r   <= btn_nxt;
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      flags_r <= flags_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_button_down   = flags_r.button_down;
  assign out_press_edge    = flags_r.press_edge;
  assign out_release_edge  = flags_r.release_edge;
  assign out_value_changed = flags_r.value_changed;
  assign out_axis_active   = flags_r.axis_active;
  assign out_axis_value    = axis_r;

endmodule

[sim/analog_trigger_to_button_test.sv]
// Testbench for analog_trigger_to_button: predicts every result beat and checks it.
module analog_trigger_to_button_test import atb_pkg::*; ();

  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    op_t                op;
    logic signed [15:0] sample;
  } trigger_cmd_t;

  typedef struct {
    logic               button_down;
    logic               press;
    logic               rel;
    logic               changed;
    logic               active;
    logic signed [15:0] value;
  } button_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_operation = OP_SET;
  logic signed [15:0]      in_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_button_down;
  logic                    out_press_edge;
  logic                    out_release_edge;
  logic                    out_value_changed;
  logic                    out_axis_active;
  logic signed [15:0]      out_axis_value;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [CfgDataWidth-1:0] pwdata = '0;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  analog_trigger_to_button dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_button_down(out_button_down), .out_press_edge(out_press_edge),
    .out_release_edge(out_release_edge), .out_value_changed(out_value_changed),
    .out_axis_active(out_axis_active), .out_axis_value(out_axis_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register mirror
  logic cfg_fast = RST_FAST_MODE;
  int   cfg_thr = RST_PRESS_THR;
  int   cfg_margin = RST_MARGIN;
  int   cfg_dead = RST_DEAD_ZONE;
  int   cfg_lo = RST_LOWER_LIM;
  int   cfg_hi = RST_UPPER_LIM;

  // Trigger state mirror
  int   lvl_now = 0;
  int   lvl_prev = 0;
  int   lvl_peak = 0;
  int   lvl_rel = 0;
  logic btn_down = 1'b0;

  trigger_cmd_t   queued_cmds[$];
  button_result_t pending_results[$];
  trigger_cmd_t   next_cmd;
  button_result_t next_result;
  button_result_t oldest_result;
  int             mismatch_count = 0;
  int             idle_cycles = 0;
  int             burst_left = 0;
  int             gap_left = 0;
  int             stall_left = 0;
  int             stall_mode = 0;
  logic           ramp_up = 1'b1;

  // Clamp, store and run the button logic for a set or a nonzero add.
  function automatic void settle_level(input int v);
    int cur;
    lvl_prev = lvl_now;
    cur = v;
    if (cur < cfg_lo) cur = cfg_lo;
    if (cur > cfg_hi) cur = cfg_hi;
    if (cur > 32767) cur = 32767;
    if (cur < -32768) cur = -32768;
    lvl_now = cur;
    if (cfg_fast) begin
      if (cur >= cfg_thr) begin
        if (cur > lvl_peak) lvl_peak = cur;
        if (!btn_down) begin
          if (cur > lvl_rel + cfg_margin) begin
            btn_down = 1'b1;
            lvl_rel = cur;
          end
        end else if (cur < lvl_peak - cfg_margin) begin
          btn_down = 1'b0;
          lvl_rel = cur;
          lvl_peak = cur;
        end
      end else if (btn_down) begin
        if (cur < lvl_peak - cfg_margin) begin
          lvl_rel = cur;
          lvl_peak = cur;
        end
        btn_down = 1'b0;
      end else begin
        lvl_peak = 0;
        lvl_rel = 0;
      end
    end else begin
      btn_down = (cur >= cfg_thr);
    end
  endfunction

  function automatic void apply_trigger_op(input op_t op, input int sample,
                                           output button_result_t r);
    logic was_down;
    logic edges;
    int   mag;
    was_down = btn_down;
    edges = 1'b0;
    case (op)
      OP_SET: begin
        settle_level(sample);
        edges = 1'b1;
      end
      OP_ADD: begin
        if (sample != 0) begin
          settle_level(lvl_now + sample);
          edges = 1'b1;
        end
      end
      OP_NEG: begin
        lvl_now = (lvl_now == -32768) ? 32767 : -lvl_now;
      end
      default: begin
        lvl_now = 0;
        lvl_prev = 0;
        lvl_peak = 0;
        lvl_rel = 0;
        btn_down = 1'b0;
      end
    endcase
    mag = (lvl_now < 0) ? -lvl_now : lvl_now;
    r.button_down = btn_down;
    r.press = edges && !was_down && btn_down;
    r.rel = edges && was_down && !btn_down;
    r.changed = (lvl_now != lvl_prev);
    r.active = (mag > cfg_dead);
    r.value = 16'(lvl_now);
  endfunction

  // Mostly ramps of small deltas and sets near the threshold, some noise.
  function automatic trigger_cmd_t random_cmd();
    trigger_cmd_t c;
    int sel;
    int t;
    sel = $urandom_range(0, 99);
    c.sample = 16'($urandom);
    if (sel < 30) begin
      c.op = OP_SET;
      if (sel < 20) begin
        t = cfg_thr + int'($urandom_range(0, 12000)) - 6000;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        c.sample = 16'(t);
      end
    end else if (sel < 75) begin
      c.op = OP_ADD;
      if ($urandom_range(0, 7) == 0) ramp_up = !ramp_up;
      t = int'($urandom_range(1, 3000));
      c.sample = 16'(ramp_up ? t : -t);
    end else if (sel < 82) begin
      c.op = OP_ADD;
    end else if (sel < 86) begin
      c.op = OP_ADD;
      c.sample = '0;
    end else if (sel < 95) begin
      c.op = OP_NEG;
    end else begin
      c.op = OP_CLR;
    end
    return c;
  endfunction

  task automatic push_cmd(input op_t op, input int s);
    queued_cmds.push_back('{op, 16'(s)});
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FAST_MODE: cfg_fast = data[0];
      REG_PRESS_THR: cfg_thr = int'($signed(data[15:0]));
      REG_MARGIN:    cfg_margin = int'(data[14:0]);
      REG_DEAD_ZONE: cfg_dead = int'(data[14:0]);
      REG_LOWER_LIM: cfg_lo = int'($signed(data[15:0]));
      REG_UPPER_LIM: cfg_hi = int'($signed(data[15:0]));
      default: ;
    endcase
  endtask

  // Hold until every queued beat has gone in and every result has come out.
  task automatic drain();
    do @(negedge clk); while (queued_cmds.size() != 0 || in_valid ||
                              pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_phase_regs(input int k);
    int thr;
    int margin;
    int dead;
    int lo;
    int hi;
    thr = (k == 2) ? -32768 : (k == 3) ? 32767 : int'($urandom_range(0, 30000)) - 8000;
    margin = (k == 4) ? 0 : (k == 5) ? 32767 : int'($urandom_range(0, 6000));
    dead = (k == 1) ? 0 : (k == 6) ? 32767 : int'($urandom_range(0, 8000));
    lo = -int'($urandom_range(8000, 32768));
    hi = (k == 3) ? 32767 : int'($urandom_range(8000, 32767));
    if (k == 7) begin
      // crossed limits: everything lands on the upper one
      lo = int'($urandom_range(1000, 20000));
      hi = lo - int'($urandom_range(1, 20000));
    end else if (k == 8) begin
      lo = -32768;
      hi = 32767;
    end else if (k == 9) begin
      lo = int'($urandom_range(0, 20000)) - 10000;
      hi = lo;
    end
    write_reg(REG_FAST_MODE, 32'(k % 3 != 0));
    write_reg(REG_PRESS_THR, 32'(thr));
    write_reg(REG_MARGIN, 32'(margin));
    write_reg(REG_DEAD_ZONE, 32'(dead));
    write_reg(REG_LOWER_LIM, 32'(lo));
    write_reg(REG_UPPER_LIM, 32'(hi));
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Sender: bursts with random gaps, predict each accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_operation <= OP_SET;
      in_sample <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_trigger_op(op_t'(in_operation), int'(in_sample), next_result);
        pending_results.push_back(next_result);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (queued_cmds.size() != 0) begin
          next_cmd = queued_cmds.pop_front();
          in_valid <= 1'b1;
          in_operation <= next_cmd.op;
          in_sample <= next_cmd.sample;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall style is redrawn whenever its countdown runs out.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      stall_mode <= 0;
    end else if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 80);
      out_stall <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 4) != 0);
        default: out_stall <= stall_left[2];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_button_down !== oldest_result.button_down)
          report_mismatch($sformatf("button_down got %b want %b",
                                    out_button_down, oldest_result.button_down));
        if (out_press_edge !== oldest_result.press)
          report_mismatch($sformatf("press_edge got %b want %b",
                                    out_press_edge, oldest_result.press));
        if (out_release_edge !== oldest_result.rel)
          report_mismatch($sformatf("release_edge got %b want %b",
                                    out_release_edge, oldest_result.rel));
        if (out_value_changed !== oldest_result.changed)
          report_mismatch($sformatf("value_changed got %b want %b",
                                    out_value_changed, oldest_result.changed));
        if (out_axis_active !== oldest_result.active)
          report_mismatch($sformatf("axis_active got %b want %b",
                                    out_axis_active, oldest_result.active));
        if (out_axis_value !== oldest_result.value)
          report_mismatch($sformatf("axis_value got %0d want %0d",
                                    out_axis_value, oldest_result.value));
      end
    end
  end

  // Watchdog: too long without any beat moving on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("analog_trigger_to_button_test: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain threshold with reset defaults
    push_cmd(OP_SET, 0);
    push_cmd(OP_SET, 16384);
    push_cmd(OP_SET, 16383);
    push_cmd(OP_ADD, 0);
    push_cmd(OP_ADD, 1);
    push_cmd(OP_ADD, 32767);
    push_cmd(OP_ADD, -32768);
    push_cmd(OP_ADD, -32768);
    push_cmd(OP_NEG, 0);
    push_cmd(OP_NEG, 0);
    push_cmd(OP_SET, -32768);
    push_cmd(OP_CLR, 0);
    drain();

    // Rapid trigger: press, peak, release on margin, forced release
    write_reg(REG_FAST_MODE, 32'd1);
    write_reg(REG_PRESS_THR, 32'd0);
    write_reg(REG_MARGIN, 32'd1000);
    write_reg(REG_DEAD_ZONE, 32'd32767);
    write_reg(REG_LOWER_LIM, 32'(-32768));
    write_reg(REG_UPPER_LIM, 32'd32767);
    push_cmd(OP_SET, -32768);
    push_cmd(OP_NEG, 0);
    push_cmd(OP_SET, 0);
    push_cmd(OP_SET, 2000);
    push_cmd(OP_SET, 5000);
    push_cmd(OP_SET, 3999);
    push_cmd(OP_SET, 5100);
    push_cmd(OP_SET, -10);
    push_cmd(OP_SET, -20);
    push_cmd(OP_ADD, 0);
    push_cmd(OP_CLR, 0);
    drain();

    for (int k = 0; k < 10; k++) begin
      set_phase_regs(k);
      repeat (90) queued_cmds.push_back(random_cmd());
      drain();
      repeat (85) queued_cmds.push_back(random_cmd());
      drain();
    end

    if (mismatch_count == 0) begin
      $display("analog_trigger_to_button_test: PASS");
    end else begin
      $display("analog_trigger_to_button_test: FAIL");
    end
    $finish;
  end

endmodule
